FILE: rtl/sm4_pkg.sv
// Shared types, constants and functions for the SM4 cipher unit.
// Holds the S-box table, FK/CK key schedule constants and the key store write type.
// No dependencies.
package sm4_pkg;

    localparam int WORD_W  = 32;
    localparam int HALF_W  = 64;
    localparam int ROUNDS  = 32;
    localparam int RND_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

    // Key schedule system parameters
    localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
    localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
    localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
    localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

    // Write side of the round key store
    typedef struct packed {
        logic              en;
        logic [RND_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } ks_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // Byte-wise S-box substitution
    function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // CK word for one key schedule step: byte j is (4*idx + j) * 7 mod 256
    function automatic logic [WORD_W-1:0] ck_word(input logic [RND_W-1:0] idx);
        logic [WORD_W-1:0] w;
        logic [7:0]        base;
        base = {1'b0, idx, 2'b00};
        for (int j = 0; j < 4; j++)
        begin
            w[WORD_W-1-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
        end
        return w;
    endfunction

endpackage

FILE: rtl/sm4_round.sv
// Shared SM4 round function: w0 ^ L(tau(x)) for data rounds, w0 ^ L'(tau(x)) for keys.
// Depends on sm4_pkg for tau and word width.
module sm4_round (
    input  logic                      key_sched,
    input  logic [sm4_pkg::WORD_W-1:0] x_in,
    input  logic [sm4_pkg::WORD_W-1:0] w0_in,
    output logic [sm4_pkg::WORD_W-1:0] word_out
);
    import sm4_pkg::*;

    logic [WORD_W-1:0] sub;
    logic [WORD_W-1:0] lin_data;
    logic [WORD_W-1:0] lin_key;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // Substitute, then apply the linear layer of the selected kind
    always_comb
    begin
        sub      = tau(x_in);
        lin_data = sub ^ rotl(sub, 2) ^ rotl(sub, 10) ^ rotl(sub, 18) ^ rotl(sub, 24);
        lin_key  = sub ^ rotl(sub, 13) ^ rotl(sub, 23);
        word_out = w0_in ^ (key_sched ? lin_key : lin_data);
    end

endmodule

FILE: rtl/sm4_key_store.sv
// Round key store: 32 x 32-bit memory, one write port, one registered read port.
// Depends on sm4_pkg for ks_wr_t.
module sm4_key_store (
    input  logic                       clk,
    input  sm4_pkg::ks_wr_t            wr,
    input  logic [sm4_pkg::RND_W-1:0]  rd_addr,
    output logic [sm4_pkg::WORD_W-1:0] rd_data
);
    import sm4_pkg::*;

    logic [WORD_W-1:0] mem [ROUNDS];
    logic [WORD_W-1:0] rd_data_reg;

    // Write round keys, read one key a cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sm4_block_cipher_unit.sv
// Top level of the SM4 block cipher unit: sequencer, word registers, config and output.
// Depends on sm4_pkg, sm4_round and sm4_key_store.
//
//  Channel  Direction  Handshake             Payload
//  cfg      in         cfg_wr_en             cfg_index, cfg_data
//  in       in         in_valid / in_ready   block_upper, block_lower
//  out      out        out_valid / out_ready result_upper, result_lower
//
// From acceptance, a block first fetches the first round key from the key store in ST_PREF,
// then runs 32 rounds through the single round unit; the last round loads the result.
// After a key write, the next block first expands the 32 round keys on the
// same round unit. in_ready is high only while the sequencer is idle.
// A result waits in the output register; the round core stalls after its last round
// only if the previous result has not been taken. Reset clears all control state.
module sm4_block_cipher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sm4_pkg::HALF_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sm4_pkg::HALF_W-1:0]    block_upper,
    input  logic [sm4_pkg::HALF_W-1:0]    block_lower,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sm4_pkg::HALF_W-1:0]    result_upper,
    output logic [sm4_pkg::HALF_W-1:0]    result_lower
);
    import sm4_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_KEYEXP = 3'd1;
    localparam logic [2:0] ST_PREF   = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [RND_W-1:0]  cnt_reg;
    logic [RND_W-1:0]  cnt_next;
    logic              keys_ready_reg;
    logic              decrypt_reg;
    logic [HALF_W-1:0] key_upper_reg;
    logic [HALF_W-1:0] key_lower_reg;
    logic [HALF_W-1:0] hold_upper_reg;
    logic [HALF_W-1:0] hold_lower_reg;
    logic [WORD_W-1:0] work_reg [4];
    logic              out_valid_reg;
    logic [HALF_W-1:0] res_upper_reg;
    logic [HALF_W-1:0] res_lower_reg;

    logic              in_xfer;
    logic              out_free;
    logic              last_cnt;
    logic              key_sched;
    logic [WORD_W-1:0] rk;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] new_word;
    logic [RND_W-1:0]  rd_addr;
    logic [RND_W-1:0]  round_sel;
    ks_wr_t            ks_wr;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last_cnt = (cnt_reg == RND_W'(ROUNDS - 1));
    assign key_sched = (state_reg == ST_KEYEXP);

    // Shared round unit
    assign x_word = work_reg[1] ^ work_reg[2] ^ work_reg[3] ^ (key_sched ? ck_word(cnt_reg) : rk);

    sm4_round u_round (
        .key_sched (key_sched),
        .x_in      (x_word),
        .w0_in     (work_reg[0]),
        .word_out  (new_word)
    );

    // Key store: write during expansion, fetch one round ahead during data rounds
    assign ks_wr.en   = key_sched;
    assign ks_wr.addr = cnt_reg;
    assign ks_wr.data = new_word;

    assign round_sel = (state_reg == ST_ROUND) ? RND_W'(cnt_reg + 1'b1) : '0;
    assign rd_addr   = decrypt_reg ? ~round_sel : round_sel;

    sm4_key_store u_key_store (
        .clk     (clk),
        .wr      (ks_wr),
        .rd_addr (rd_addr),
        .rd_data (rk)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = keys_ready_reg ? ST_PREF : ST_KEYEXP;
                    cnt_next   = '0;
                end
            end
            ST_KEYEXP:
            begin
                cnt_next = RND_W'(cnt_reg + 1'b1);
                if (last_cnt)
                begin
                    state_next = ST_PREF;
                end
            end
            ST_PREF:
            begin
                state_next = ST_ROUND;
                cnt_next   = '0;
            end
            ST_ROUND:
            begin
                cnt_next = RND_W'(cnt_reg + 1'b1);
                if (last_cnt)
                begin
                    state_next = out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            keys_ready_reg <= 1'b0;
            decrypt_reg    <= 1'b0;
            key_upper_reg  <= '0;
            key_lower_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            // Mark keys expanded at the end of the schedule; drop on key writes
            if (key_sched && last_cnt)
            begin
                keys_ready_reg <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_KEY_UPPER:
                    begin
                        key_upper_reg  <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    CFG_KEY_LOWER:
                    begin
                        key_lower_reg  <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    CFG_DECRYPT_MODE:
                    begin
                        decrypt_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Output valid: set when a result loads, clear when it is taken
            if (((state_reg == ST_ROUND && last_cnt) || state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Word registers, held block and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hold_upper_reg <= block_upper;
            hold_lower_reg <= block_lower;
            if (keys_ready_reg)
            begin
                work_reg[0] <= block_upper[63:32];
                work_reg[1] <= block_upper[31:0];
                work_reg[2] <= block_lower[63:32];
                work_reg[3] <= block_lower[31:0];
            end
            else
            begin
                work_reg[0] <= key_upper_reg[63:32] ^ FK0;
                work_reg[1] <= key_upper_reg[31:0] ^ FK1;
                work_reg[2] <= key_lower_reg[63:32] ^ FK2;
                work_reg[3] <= key_lower_reg[31:0] ^ FK3;
            end
        end
        else if (key_sched && last_cnt)
        begin
            // Schedule done: bring in the held block
            work_reg[0] <= hold_upper_reg[63:32];
            work_reg[1] <= hold_upper_reg[31:0];
            work_reg[2] <= hold_lower_reg[63:32];
            work_reg[3] <= hold_lower_reg[31:0];
        end
        else if (key_sched || state_reg == ST_ROUND)
        begin
            // Advance one round
            work_reg[0] <= work_reg[1];
            work_reg[1] <= work_reg[2];
            work_reg[2] <= work_reg[3];
            work_reg[3] <= new_word;
        end

        // Load result in reversed word order
        if (state_reg == ST_ROUND && last_cnt && out_free)
        begin
            res_upper_reg <= {new_word, work_reg[3]};
            res_lower_reg <= {work_reg[2], work_reg[1]};
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            res_upper_reg <= {work_reg[3], work_reg[2]};
            res_lower_reg <= {work_reg[1], work_reg[0]};
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_upper = res_upper_reg;
    assign result_lower = res_lower_reg;

    // Key expansion only runs while cached keys are stale
    a_keyexp_stale: assert property (@(posedge clk) disable iff (!rst_n)
        key_sched |-> !keys_ready_reg)
        else $error("key expansion with keys already marked ready");

    // An accepted block starts either key expansion or the key fetch
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_KEYEXP || state_reg == ST_PREF))
        else $error("accepted block did not start processing");

    // A new result appears only after the last round or a stalled finish
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_ROUND || $past(state_reg) == ST_DONE))
        else $error("result raised outside round completion");

    // Data rounds never start with stale keys
    a_pref_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREF) |-> keys_ready_reg)
        else $error("data rounds started without expanded keys");

endmodule
